// File: hw/rtl/zrpe_pkg.sv
`default_nettype none

package zrpe_pkg;

    // Fixed sizes of the expanded image.
    localparam int PAGE_SIZE  = 256;
    localparam int MAX_PAGES  = 512;
    localparam int WORD_BYTES = 8;

    localparam int PAGE_LG  = $clog2(PAGE_SIZE);
    localparam int LANE_W   = $clog2(WORD_BYTES);
    localparam int PAGES_W  = 10;
    localparam int TOTAL_W  = $clog2(MAX_PAGES * PAGE_SIZE) + 1;
    localparam int WORD_W   = 8 * WORD_BYTES;
    localparam int PART_W   = WORD_W - 8;
    localparam int ROOM_W   = LANE_W + 1;

    // Command queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Result status codes.
    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_COMPLETE  = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_TOO_SMALL = 3'd3;
    localparam logic [2:0] ST_NO_COUNT  = 3'd4;

    // Input kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // Command codes.
    localparam logic [1:0] OP_LIT = 2'd0;
    localparam logic [1:0] OP_RUN = 2'd1;
    localparam logic [1:0] OP_EOS = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] arg;   // literal byte, or number of extra zeros of a run
        logic       flag;  // end of stream: a count byte was still due
    } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/zrpe_front.sv
`default_nettype none

module zrpe_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic          kind,
    input  wire logic [7:0]    data_byte,
    output logic               push,
    output zrpe_pkg::cmd_t     cmd
);
    import zrpe_pkg::*;

    logic awaiting_reg;
    logic awaiting_next;

    // A zero byte makes the following data byte a count byte. A count of one
    // adds no zeros and needs no command.
    always_comb
    begin
        awaiting_next = awaiting_reg;
        push          = 1'b0;
        cmd.op        = OP_LIT;
        cmd.arg       = data_byte;
        cmd.flag      = 1'b0;
        if (accept)
        begin
            if (kind == KIND_EOS)
            begin
                push          = 1'b1;
                cmd.op        = OP_EOS;
                cmd.flag      = awaiting_reg;
                awaiting_next = 1'b0;
            end
            else if (awaiting_reg)
            begin
                cmd.op        = OP_RUN;
                cmd.arg       = data_byte - 8'd1;
                push          = (data_byte != 8'd1);
                awaiting_next = 1'b0;
            end
            else
            begin
                push          = 1'b1;
                awaiting_next = (data_byte == 8'd0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/zrpe_queue.sv
`default_nettype none

module zrpe_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire zrpe_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output zrpe_pkg::cmd_t     head
);
    import zrpe_pkg::*;

    cmd_t               q_reg [Q_DEPTH];
    logic [Q_AW-1:0]    wr_ptr_reg;
    logic [Q_AW-1:0]    rd_ptr_reg;
    logic [Q_AW:0]      count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (Q_AW+1)'(1);
                2'b01:   count_reg <= count_reg - (Q_AW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/zrpe_back.sv
`default_nettype none

module zrpe_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      head_valid,
    input  wire zrpe_pkg::cmd_t            head,
    input  wire logic [zrpe_pkg::PAGES_W-1:0] expected_pages,
    input  wire logic                      out_ready,
    output logic                           pop,
    output logic                           out_valid,
    output logic [2:0]                     status,
    output logic [zrpe_pkg::WORD_W-1:0]    word,
    output logic                           page_end,
    output logic                           last_of_item
);
    import zrpe_pkg::*;

    // Expansion state.
    logic [PART_W-1:0]  partial_reg, partial_next;
    logic [LANE_W-1:0]  lane_reg, lane_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               err_reg, err_next;
    logic [7:0]         rem_reg, rem_next;
    logic               run_act_reg, run_act_next;
    logic               phase_reg, phase_next;

    // Output holding register.
    logic               out_valid_reg;
    logic [2:0]         status_reg;
    logic [WORD_W-1:0]  word_reg;
    logic               page_end_reg;
    logic               last_reg;

    logic               res_valid;
    logic [2:0]         res_status;
    logic [WORD_W-1:0]  res_word;
    logic               res_pe;
    logic               res_last;
    logic               clear;
    logic               step;

    logic [PAGES_W-1:0] pages_sat;
    logic [TOTAL_W-1:0] exp_bytes;
    logic [TOTAL_W-1:0] cap;
    logic [WORD_W-1:0]  assembled;
    logic [TOTAL_W-1:0] total_inc;
    logic [7:0]         rem_cur;
    logic [ROOM_W-1:0]  room;
    logic [ROOM_W-1:0]  k_room;
    logic [ROOM_W-1:0]  k;
    logic [ROOM_W-1:0]  lane_sum;
    logic [TOTAL_W-1:0] total_run;
    logic [7:0]         new_rem;
    logic               more;

    assign pages_sat = (expected_pages > PAGES_W'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES)
                                                               : expected_pages;
    assign exp_bytes = TOTAL_W'({pages_sat, {PAGE_LG{1'b0}}});
    assign cap       = (total_reg >= exp_bytes) ? '0 : (exp_bytes - total_reg);

    // Literal path: one byte into the current lane.
    assign assembled = {8'h00, partial_reg}
                     | (WORD_W'(head.arg) << {lane_reg, 3'b000});
    assign total_inc = total_reg + TOTAL_W'(1);

    // Run path: as many zeros as the lane room, the run and the capacity allow.
    assign rem_cur   = run_act_reg ? rem_reg : head.arg;
    assign room      = ROOM_W'(WORD_BYTES) - {1'b0, lane_reg};
    assign k_room    = ({{(8-ROOM_W){1'b0}}, room} > rem_cur) ? rem_cur[ROOM_W-1:0] : room;
    assign k         = (cap < TOTAL_W'(k_room)) ? cap[ROOM_W-1:0] : k_room;
    assign lane_sum  = {1'b0, lane_reg} + k;
    assign total_run = total_reg + TOTAL_W'(k);
    assign new_rem   = rem_cur - 8'(k);
    assign more      = (new_rem >= 8'(WORD_BYTES)) || (TOTAL_W'(new_rem) > (cap - TOTAL_W'(k)));

    assign step = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        partial_next = partial_reg;
        lane_next    = lane_reg;
        total_next   = total_reg;
        err_next     = err_reg;
        rem_next     = rem_reg;
        run_act_next = run_act_reg;
        phase_next   = phase_reg;
        pop          = 1'b0;
        clear        = 1'b0;
        res_valid    = 1'b0;
        res_status   = ST_DATA;
        res_word     = '0;
        res_pe       = 1'b0;
        res_last     = 1'b0;
        if (step)
        begin
            unique case (head.op)
                OP_LIT:
                begin
                    pop = 1'b1;
                    if (!err_reg)
                    begin
                        if (cap == '0)
                        begin
                            res_valid    = 1'b1;
                            res_status   = ST_TOO_LARGE;
                            res_last     = 1'b1;
                            err_next     = 1'b1;
                            partial_next = '0;
                            lane_next    = '0;
                        end
                        else
                        begin
                            total_next = total_inc;
                            if (lane_reg == LANE_W'(WORD_BYTES - 1))
                            begin
                                res_valid    = 1'b1;
                                res_word     = assembled;
                                res_pe       = (total_inc[PAGE_LG-1:0] == '0);
                                res_last     = 1'b1;
                                partial_next = '0;
                                lane_next    = '0;
                            end
                            else
                            begin
                                partial_next = assembled[PART_W-1:0];
                                lane_next    = lane_reg + LANE_W'(1);
                            end
                        end
                    end
                end
                OP_RUN:
                begin
                    if (err_reg)
                    begin
                        pop          = 1'b1;
                        run_act_next = 1'b0;
                    end
                    else if (cap == '0)
                    begin
                        res_valid    = 1'b1;
                        res_status   = ST_TOO_LARGE;
                        res_last     = 1'b1;
                        err_next     = 1'b1;
                        partial_next = '0;
                        lane_next    = '0;
                        pop          = 1'b1;
                        run_act_next = 1'b0;
                    end
                    else
                    begin
                        lane_next  = lane_sum[LANE_W-1:0];
                        total_next = total_run;
                        if (lane_sum[LANE_W])
                        begin
                            res_valid    = 1'b1;
                            res_word     = {8'h00, partial_reg};
                            res_pe       = (total_run[PAGE_LG-1:0] == '0);
                            res_last     = !more;
                            partial_next = '0;
                        end
                        if (new_rem == 8'd0)
                        begin
                            pop          = 1'b1;
                            run_act_next = 1'b0;
                        end
                        else
                        begin
                            rem_next     = new_rem;
                            run_act_next = 1'b1;
                        end
                    end
                end
                OP_EOS:
                begin
                    if (err_reg)
                    begin
                        pop   = 1'b1;
                        clear = 1'b1;
                    end
                    else if (head.flag)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_NO_COUNT;
                        res_last   = 1'b1;
                        pop        = 1'b1;
                        clear      = 1'b1;
                    end
                    else if (total_reg != exp_bytes)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_TOO_SMALL;
                        res_last   = 1'b1;
                        pop        = 1'b1;
                        clear      = 1'b1;
                    end
                    else if ((lane_reg != '0) && !phase_reg)
                    begin
                        res_valid  = 1'b1;
                        res_word   = {8'h00, partial_reg};
                        res_pe     = (total_reg[PAGE_LG-1:0] == '0);
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_COMPLETE;
                        res_last   = 1'b1;
                        pop        = 1'b1;
                        clear      = 1'b1;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
        if (clear)
        begin
            partial_next = '0;
            lane_next    = '0;
            total_next   = '0;
            err_next     = 1'b0;
            rem_next     = '0;
            run_act_next = 1'b0;
            phase_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            lane_reg      <= '0;
            total_reg     <= '0;
            err_reg       <= 1'b0;
            rem_reg       <= '0;
            run_act_reg   <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
            lane_reg    <= lane_next;
            total_reg   <= total_next;
            err_reg     <= err_next;
            rem_reg     <= rem_next;
            run_act_reg <= run_act_next;
            phase_reg   <= phase_next;
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            status_reg   <= res_status;
            word_reg     <= res_word;
            page_end_reg <= res_pe;
            last_reg     <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign word         = word_reg;
    assign page_end     = page_end_reg;
    assign last_of_item = last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/zero_run_page_expander_top.sv
`default_nettype none

// Zero-run page expander. Each input word carries one compressed byte or an
// end-of-stream mark; nonzero bytes are copied, and a zero byte is followed by
// a count byte that adds (count - 1) mod 256 more zeros. Expanded bytes come
// out packed eight to a 64-bit word, first byte in bits 7 to 0, with page_end
// set on the word that completes a 256-byte page. The image must hold exactly
// expected_pages pages (values above 512 act as 512); otherwise a status word
// reports too large, too small or a missing count byte, and after an error
// nothing more comes out until the end-of-stream word, which restarts the
// expander. The front end classifies each input word in the cycle it is
// accepted and places a command in a four-entry queue, so literal bytes and
// count bytes are taken one per cycle as long as the queue has room. The
// back end executes one step per cycle whenever its output register is empty
// or being emptied: a literal is one step, a run of extra zeros is expanded
// one step for each stretch up to the next word boundary, a run that overflows
// ends in a step that gives the status word, and end of stream gives its
// status word after any partial word is flushed. While a run is being expanded
// the queue can fill, and input then stalls. Each result sits in an output
// register, and the back end stalls while a finished word waits there to be
// taken. expected_pages is written through cfg_wr_en and cfg_wr_data and
// should only be changed while the block is idle.
module zero_run_page_expander_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [zrpe_pkg::PAGES_W-1:0]   cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           kind,
    input  wire logic [7:0]                     data_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          status,
    output logic [zrpe_pkg::WORD_W-1:0]         word,
    output logic                                page_end,
    output logic                                last_of_item
);
    import zrpe_pkg::*;

    // Configured page count; reset gives the largest image.
    logic [PAGES_W-1:0] expected_pages_reg;

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic head_valid;
    cmd_t head;
    logic pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pages_reg <= PAGES_W'(MAX_PAGES);
        end
        else if (cfg_wr_en)
        begin
            expected_pages_reg <= cfg_wr_data;
        end
    end

    // The front end can always take a word when the queue has a free slot.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    zrpe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (kind),
        .data_byte (data_byte),
        .push      (push),
        .cmd       (push_cmd)
    );

    zrpe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // The back end keeps the packing state and the output register.
    zrpe_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head           (head),
        .expected_pages (expected_pages_reg),
        .out_ready      (out_ready),
        .pop            (pop),
        .out_valid      (out_valid),
        .status         (status),
        .word           (word),
        .page_end       (page_end),
        .last_of_item   (last_of_item)
    );

endmodule

`default_nettype wire
